[sv/skt_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted key table package
// Shared sizes, codes, entry and sequencer state types.
// ----------------------------------------------------------------------------
package skt_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = 7;

    typedef enum logic [1:0] {
        OP_INSERT    = 2'd0,
        OP_REMOVE    = 2'd1,
        OP_LIST_ASC  = 2'd2,
        OP_LIST_DESC = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_FULL      = 3'd1,
        ST_REMOVED   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_LISTED    = 3'd4
    } t_status;

    typedef struct packed {
        logic signed [31:0] key;
        logic        [31:0] payload;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PUT,
        S_RESP,
        S_LIST_RD,
        S_LIST_OUT
    } t_state;

endpackage

[sv/skt_if.sv]
// ----------------------------------------------------------------------------
// Sorted key table channels
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface skt_in_if;
    import skt_pkg::*;

    logic               valid;
    logic               ready;
    t_op                op;
    logic signed [31:0] key;
    logic        [31:0] payload;

    modport source (output valid, output op, output key, output payload, input ready);
    modport sink   (input valid, input op, input key, input payload, output ready);
endinterface

interface skt_out_if;
    import skt_pkg::*;

    logic               valid;
    logic               ready;
    t_status            status;
    logic signed [31:0] entry_key;
    logic        [31:0] entry_payload;
    logic [CNT_W-1:0]   count;
    logic               empty_list;
    logic               last;

    modport source (output valid, output status, output entry_key, output entry_payload,
                    output count, output empty_list, output last, input ready);
    modport sink   (input valid, input status, input entry_key, input entry_payload,
                    input count, input empty_list, input last, output ready);
endinterface

[sv/skt_store.sv]
// ----------------------------------------------------------------------------
// Sorted key table entry store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module skt_store (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [skt_pkg::IDX_W-1:0] i_waddr,
    input  skt_pkg::t_entry      i_wdata,
    input  logic [skt_pkg::IDX_W-1:0] i_raddr,
    output skt_pkg::t_entry      o_rdata
);
    import skt_pkg::*;

    t_entry r_mem [CAPACITY];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/sorted_key_table.sv]
// ----------------------------------------------------------------------------
// Sorted key table
// Keeps up to CAPACITY key/payload entries in ascending signed key order.
// ----------------------------------------------------------------------------
// A request is taken only while the table is idle, and every result beat
// leaves through one output register. The entries live in a store with one
// write port and one read port with a registered read. One signed magnitude
// comparator and one equality check serve every step, so each visited or
// moved entry takes a read state and then a check or write state. An insert
// into an empty table goes straight to the write of the new entry, and a full
// insert, an empty listing and a remove on an empty table go straight to the
// response. The longest request is an insert into a table of CAPACITY-1
// entries. A result beat that finds the output register still held waits in
// its state until the register is free.
// ----------------------------------------------------------------------------
module sorted_key_table (
    input  logic     i_clk,
    input  logic     i_rst_n,
    skt_in_if.sink   i_in,
    skt_out_if.source o_out
);
    import skt_pkg::*;

    t_state           r_state, n_state;
    t_op              r_op;
    logic signed [31:0] r_key;
    logic        [31:0] r_pay;
    logic [CNT_W-1:0] r_cnt;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_pos;
    t_status          r_status;
    logic signed [31:0] r_rk;
    logic        [31:0] r_rp;
    logic             r_empty;

    logic             r_ov;
    t_status          r_o_status;
    logic signed [31:0] r_o_key;
    logic        [31:0] r_o_pay;
    logic [CNT_W-1:0] r_o_cnt;
    logic             r_o_empty;
    logic             r_o_last;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    t_entry           mem_wdata;
    logic [IDX_W-1:0] mem_raddr;
    t_entry           rd;

    logic             in_acc;
    logic             slot_free;
    logic             out_load;
    logic             key_lt;
    logic             ent_lt;
    logic             key_eq;
    logic             idx_is_last;
    logic             ins_hit;
    logic             list_last;
    logic             is_ins;

    skt_store u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (rd)
    );

    assign in_acc      = i_in.valid && i_in.ready;
    assign slot_free   = !r_ov || o_out.ready;
    assign out_load    = slot_free && (r_state == S_RESP || r_state == S_LIST_OUT);
    assign ent_lt      = rd.key < r_key;
    assign key_eq      = rd.key == r_key;
    assign key_lt      = !ent_lt && !key_eq;
    assign idx_is_last = CNT_W'(r_idx) == (r_cnt - CNT_W'(1));
    assign ins_hit     = (r_idx == '0) ? key_lt : !ent_lt;
    assign is_ins      = r_op == OP_INSERT;
    assign list_last   = (r_op == OP_LIST_ASC) ? idx_is_last : (r_idx == '0);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    priority if (i_in.op == OP_INSERT) begin
                        if (r_cnt >= CNT_W'(CAPACITY)) n_state = S_RESP;
                        else if (r_cnt == '0) n_state = S_PUT;
                        else n_state = S_SCAN_RD;
                    end else if (i_in.op == OP_REMOVE) begin
                        n_state = (r_cnt == '0) ? S_RESP : S_SCAN_RD;
                    end else begin
                        n_state = (r_cnt == '0) ? S_RESP : S_LIST_RD;
                    end
                end
            end
            S_SCAN_RD:  n_state = S_SCAN_CHK;
            S_SCAN_CHK: begin
                if (is_ins) begin
                    if (ins_hit) n_state = S_SHIFT_RD;
                    else if (idx_is_last) n_state = S_PUT;
                    else n_state = S_SCAN_RD;
                end else begin
                    if (key_eq) n_state = idx_is_last ? S_RESP : S_SHIFT_RD;
                    else n_state = idx_is_last ? S_RESP : S_SCAN_RD;
                end
            end
            S_SHIFT_RD: n_state = S_SHIFT_WR;
            S_SHIFT_WR: begin
                if (is_ins) begin
                    n_state = (r_idx == r_pos) ? S_PUT : S_SHIFT_RD;
                end else begin
                    n_state = (CNT_W'(r_idx) + CNT_W'(2) >= r_cnt) ? S_RESP : S_SHIFT_RD;
                end
            end
            S_PUT:      n_state = S_RESP;
            S_RESP:     n_state = slot_free ? S_IDLE : S_RESP;
            S_LIST_RD:  n_state = S_LIST_OUT;
            S_LIST_OUT: begin
                if (slot_free) n_state = list_last ? S_IDLE : S_LIST_RD;
            end
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready = r_state == S_IDLE;
        mem_we     = 1'b0;
        mem_waddr  = r_pos;
        mem_wdata  = rd;
        mem_raddr  = r_idx;
        unique case (r_state)
            S_SHIFT_RD: begin
                mem_raddr = is_ins ? r_idx : r_idx + IDX_W'(1);
            end
            S_SHIFT_WR: begin
                mem_we    = 1'b1;
                mem_waddr = is_ins ? r_idx + IDX_W'(1) : r_idx;
            end
            S_PUT: begin
                mem_we    = 1'b1;
                mem_wdata = '{key: r_key, payload: r_pay};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) r_ov <= 1'b1;
            else if (o_out.ready) r_ov <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_op    <= i_in.op;
                        r_key   <= i_in.key;
                        r_pay   <= i_in.payload;
                        r_rk    <= '0;
                        r_rp    <= '0;
                        r_empty <= (i_in.op == OP_LIST_ASC || i_in.op == OP_LIST_DESC)
                                   && r_cnt == '0;
                        r_idx   <= (i_in.op == OP_LIST_DESC) ? IDX_W'(r_cnt - CNT_W'(1))
                                                             : '0;
                        r_pos   <= '0;
                        priority if (i_in.op == OP_INSERT) begin
                            r_status <= (r_cnt >= CNT_W'(CAPACITY)) ? ST_FULL : ST_INSERTED;
                        end else if (i_in.op == OP_REMOVE) begin
                            r_status <= ST_NOT_FOUND;
                        end else begin
                            r_status <= ST_LISTED;
                        end
                    end
                end
                S_SCAN_CHK: begin
                    if (is_ins) begin
                        if (ins_hit) begin
                            r_pos <= r_idx;
                            r_idx <= IDX_W'(r_cnt - CNT_W'(1));
                        end else if (idx_is_last) begin
                            r_pos <= r_idx + IDX_W'(1);
                        end else begin
                            r_idx <= r_idx + IDX_W'(1);
                        end
                    end else if (key_eq) begin
                        r_rk     <= rd.key;
                        r_rp     <= rd.payload;
                        r_status <= ST_REMOVED;
                        if (idx_is_last) r_cnt <= r_cnt - CNT_W'(1);
                    end else if (!idx_is_last) begin
                        r_idx <= r_idx + IDX_W'(1);
                    end
                end
                S_SHIFT_WR: begin
                    if (is_ins) begin
                        r_idx <= r_idx - IDX_W'(1);
                    end else if (CNT_W'(r_idx) + CNT_W'(2) >= r_cnt) begin
                        r_cnt <= r_cnt - CNT_W'(1);
                    end else begin
                        r_idx <= r_idx + IDX_W'(1);
                    end
                end
                S_PUT: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
                S_RESP: begin
                    if (slot_free) begin
                        r_o_status <= r_status;
                        r_o_key    <= r_rk;
                        r_o_pay    <= r_rp;
                        r_o_cnt    <= r_cnt;
                        r_o_empty  <= r_empty;
                        r_o_last   <= 1'b1;
                    end
                end
                S_LIST_OUT: begin
                    if (slot_free) begin
                        r_o_status <= ST_LISTED;
                        r_o_key    <= rd.key;
                        r_o_pay    <= rd.payload;
                        r_o_cnt    <= r_cnt;
                        r_o_empty  <= 1'b0;
                        r_o_last   <= list_last;
                        r_idx      <= (r_op == OP_LIST_ASC) ? r_idx + IDX_W'(1)
                                                           : r_idx - IDX_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out.valid         = r_ov;
    assign o_out.status        = r_o_status;
    assign o_out.entry_key     = r_o_key;
    assign o_out.entry_payload = r_o_pay;
    assign o_out.count         = r_o_cnt;
    assign o_out.empty_list    = r_o_empty;
    assign o_out.last          = r_o_last;

endmodule
